>>> rtl/fss_pkg.sv
// fss_pkg: shared types, constants and character-class helpers for the
// fuzzy subsequence scorer. No dependencies; imported by every RTL file.
`default_nettype none

package fss_pkg;

    // Fixed field widths
    localparam int CHAR_W  = 8;
    localparam int TOTAL_W = 11;
    localparam int SCORE_W = 12;
    localparam int GAP_W   = 3;
    localparam int SLASH_W = 10;
    localparam int QLEN_W  = 6;
    localparam int CFG_W   = 64;
    localparam int CIDX_W  = 3;

    // Scoring constants
    localparam int SCORE_BASE     = 16;
    localparam int BONUS_CONSEC   = 8;
    localparam int BONUS_BOUNDARY = 12;
    localparam int BONUS_UPPER    = 2;
    localparam int GAP_SAT        = 6;
    localparam int SEG_BONUS      = 24;
    localparam int SLASH_SAT      = 1023;

    localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [CHAR_W-1:0] CH_UNDER  = 8'h5F;
    localparam logic [CHAR_W-1:0] CH_DASH   = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_DOLLAR = 8'h24;

    // Configuration register indexes
    typedef enum logic [CIDX_W-1:0] {
        REG_PATH_MODE = 3'd0,
        REG_QUERY_LEN = 3'd1,
        REG_QUERY_0   = 3'd2,
        REG_QUERY_1   = 3'd3,
        REG_QUERY_2   = 3'd4,
        REG_QUERY_3   = 3'd5
    } t_cfg_reg;

    // Per-character control for one matching lane
    typedef struct packed {
        logic step;        // feed the current character
        logic clear;       // return to the start-of-lane state after this cycle
        logic first;       // first character seen by the lane
        logic prev_lower;  // previous lane character was lower case
    } t_lane_ctl;

    // Lane status after the current character
    typedef struct packed {
        logic               done;   // whole query consumed
        logic [TOTAL_W-1:0] total;
    } t_lane_stat;

    function automatic logic is_up(input logic [CHAR_W-1:0] c);
        return (c >= 8'h41) && (c <= 8'h5A);
    endfunction

    function automatic logic is_lo(input logic [CHAR_W-1:0] c);
        return (c >= 8'h61) && (c <= 8'h7A);
    endfunction

    function automatic logic [CHAR_W-1:0] fold(input logic [CHAR_W-1:0] c);
        return is_up(c) ? (c | 8'h20) : c;
    endfunction

    function automatic logic is_sep(input logic [CHAR_W-1:0] c);
        return (c == CH_SLASH) || (c == CH_BSLASH) || (c == CH_UNDER) || (c == CH_DASH) ||
               (c == CH_DOT) || (c == CH_SPACE) || (c == CH_DOLLAR);
    endfunction

endpackage

`default_nettype wire

>>> rtl/fss_if.sv
// fss_if: request channel interfaces for candidate characters and results.
// Depends on fss_pkg for field widths.
`default_nettype none

interface fss_in_if import fss_pkg::*; ;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface fss_out_if import fss_pkg::*; ;
    logic                      valid;
    logic                      ready;
    logic                      matched;
    logic signed [SCORE_W-1:0] match_score;

    modport source (output valid, output matched, output match_score, input ready);
    modport sink   (input valid, input matched, input match_score, output ready);
endinterface

`default_nettype wire

>>> rtl/fss_lane.sv
// fss_lane: one greedy case-insensitive subsequence matching lane with its
// running score. Depends on fss_pkg.
`default_nettype none

module fss_lane
    import fss_pkg::*;
#(
    parameter int QUERY_MAX = 32,
    parameter int QP_W      = 6
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_lane_ctl                i_ctl,
    input  wire logic [CHAR_W-1:0]        i_char,
    input  wire logic [QP_W-1:0]          i_qlen,
    input  wire logic [8*QUERY_MAX-1:0]   i_query,
    output t_lane_stat                    o_stat
);

    localparam int QI_W = (QUERY_MAX > 1) ? $clog2(QUERY_MAX) : 1;

    logic [QP_W-1:0]    r_qpos,  n_qpos;
    logic [TOTAL_W-1:0] r_total, n_total;
    logic               r_prevm, n_prevm;
    logic               r_bnd,   n_bnd;
    logic [GAP_W-1:0]   r_gap,   n_gap;
    logic               r_any,   n_any;

    logic [QI_W-1:0]    w_qidx;
    logic [CHAR_W-1:0]  w_qchar;
    logic               w_active;
    logic               w_hit;
    logic               w_upper;
    logic               w_bnext;
    logic [5:0]         w_gain;

    // Query character at the lane position
    assign w_qidx   = r_qpos[QI_W-1:0];
    assign w_qchar  = i_query[8*w_qidx +: 8];
    assign w_active = r_qpos < i_qlen;
    assign w_hit    = fold(i_char) == fold(w_qchar);
    assign w_upper  = is_up(i_char);
    assign w_bnext  = is_sep(i_char) || (!i_ctl.first && i_ctl.prev_lower && w_upper);

    // Points for a matched character
    assign w_gain = 6'(SCORE_BASE)
                  + (r_prevm ? 6'(BONUS_CONSEC) : 6'd0)
                  + ((r_bnd || i_ctl.first) ? 6'(BONUS_BOUNDARY) : 6'd0)
                  + (w_upper ? 6'(BONUS_UPPER) : 6'd0)
                  - ((r_any && (r_gap != '0)) ? {3'b000, r_gap} : 6'd0);

    // Lane next state
    always_comb begin
        n_qpos  = r_qpos;
        n_total = r_total;
        n_prevm = r_prevm;
        n_bnd   = r_bnd;
        n_gap   = r_gap;
        n_any   = r_any;
        if (i_ctl.step && w_active) begin
            if (w_hit) begin
                n_total = r_total + {{(TOTAL_W-6){1'b0}}, w_gain};
                n_qpos  = r_qpos + 1'b1;
                n_prevm = 1'b1;
                n_gap   = '0;
                n_any   = 1'b1;
            end else begin
                n_prevm = 1'b0;
                if (r_gap < GAP_W'(GAP_SAT)) begin
                    n_gap = r_gap + 1'b1;
                end
            end
            n_bnd = w_bnext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_qpos  <= '0;
            r_total <= '0;
            r_prevm <= 1'b0;
            r_bnd   <= 1'b1;
            r_gap   <= '0;
            r_any   <= 1'b0;
        end else begin
            r_qpos  <= n_qpos;
            r_total <= n_total;
            r_prevm <= n_prevm;
            r_bnd   <= n_bnd;
            r_gap   <= n_gap;
            r_any   <= n_any;
        end
    end

    assign o_stat.done  = n_qpos >= i_qlen;
    assign o_stat.total = n_total;

endmodule

`default_nettype wire

>>> rtl/fuzzy_subsequence_scorer.sv
// Fuzzy subsequence scorer: takes one candidate character per cycle unless a
// final character is held for a full snapshot, and gives one result per
// character marked last_char, passing through the input register, the lane
// update into a result snapshot and the score register. The rate is set by
// the per-character lane update: a query byte select, a case-folded compare
// and a small add into the 11-bit running total, for the full lane and the
// segment lane side by side. Results stall without loss; the input keeps
// flowing while non-final characters arrive. Write configuration only while
// no candidate is in flight. Depends on fss_pkg, fss_if and fss_lane.
`default_nettype none

module fuzzy_subsequence_scorer
    import fss_pkg::*;
#(
    parameter int QUERY_MAX = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [CIDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]  i_cfg_data,
    fss_in_if.sink                 i_cand,
    fss_out_if.source              o_res
);

    localparam int QP_W = $clog2(QUERY_MAX + 1);

    // Configuration registers
    logic               r_path_mode;
    logic [QLEN_W-1:0]  r_query_length;
    logic [7:0]         r_query [QUERY_MAX];
    logic [8*QUERY_MAX-1:0] w_query;
    logic [QP_W-1:0]    w_qlen;
    logic               w_is_query;
    logic [1:0]         w_qword;

    assign w_is_query = i_cfg_index inside {[REG_QUERY_0:REG_QUERY_3]};
    assign w_qword    = 2'(i_cfg_index - REG_QUERY_0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_path_mode    <= 1'b0;
            r_query_length <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_PATH_MODE: r_path_mode    <= i_cfg_data[0];
                REG_QUERY_LEN: r_query_length <= i_cfg_data[QLEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Query bytes; bytes beyond QUERY_MAX are dropped
    always_ff @(posedge i_clk) begin
        for (int b = 0; b < QUERY_MAX; b++) begin
            if (!i_rst_n) begin
                r_query[b] <= '0;
            end else if (i_cfg_we && w_is_query && (w_qword == 2'(b >> 3))) begin
                r_query[b] <= i_cfg_data[8*(b & 7) +: 8];
            end
        end
    end

    always_comb begin
        for (int b = 0; b < QUERY_MAX; b++) begin
            w_query[8*b +: 8] = r_query[b];
        end
    end

    // Effective query length, clamped to the storage
    assign w_qlen = (r_query_length > QLEN_W'(QUERY_MAX)) ? QP_W'(QUERY_MAX)
                                                            : r_query_length[QP_W-1:0];

    // Handshake across the three stages
    logic r_in_valid, r_snap_valid, r_out_valid;
    logic w_in_adv, w_snap_ready, w_snap_adv, w_out_ready;

    assign w_out_ready  = !r_out_valid || o_res.ready;
    assign w_snap_ready = !r_snap_valid || w_out_ready;
    assign w_snap_adv   = r_snap_valid && w_out_ready;

    // Input register
    logic [CHAR_W-1:0] r_in_char;
    logic              r_in_last;

    assign w_in_adv     = r_in_valid && (!r_in_last || w_snap_ready);
    assign i_cand.ready = !r_in_valid || w_in_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_cand.ready) begin
            r_in_valid <= i_cand.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cand.valid && i_cand.ready) begin
            r_in_char <= i_cand.char_code;
            r_in_last <= i_cand.last_char;
        end
    end

    // Per-candidate shared state
    logic               r_at_start,       n_at_start;
    logic               r_prev_lower,     n_prev_lower;
    logic               r_seg_nonempty,   n_seg_nonempty;
    logic               r_seg_prev_lower, n_seg_prev_lower;
    logic [SLASH_W-1:0] r_slash,          n_slash;
    logic               w_slash;
    logic               w_lower;

    assign w_slash = r_in_char == CH_SLASH;
    assign w_lower = is_lo(r_in_char);

    always_comb begin
        n_at_start       = 1'b0;
        n_prev_lower     = w_lower;
        n_seg_nonempty   = !w_slash;
        n_seg_prev_lower = !w_slash && w_lower;
        n_slash          = r_slash;
        if (w_slash && (r_slash < SLASH_W'(SLASH_SAT))) begin
            n_slash = r_slash + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_in_adv && r_in_last)) begin
            r_at_start       <= 1'b1;
            r_prev_lower     <= 1'b0;
            r_seg_nonempty   <= 1'b0;
            r_seg_prev_lower <= 1'b0;
            r_slash          <= '0;
        end else if (w_in_adv) begin
            r_at_start       <= n_at_start;
            r_prev_lower     <= n_prev_lower;
            r_seg_nonempty   <= n_seg_nonempty;
            r_seg_prev_lower <= n_seg_prev_lower;
            r_slash          <= n_slash;
        end
    end

    // Matching lanes: whole candidate, and the segment after the last slash
    t_lane_ctl  w_full_ctl, w_seg_ctl;
    t_lane_stat w_full_stat, w_seg_stat;

    assign w_full_ctl.step       = w_in_adv;
    assign w_full_ctl.clear      = w_in_adv && r_in_last;
    assign w_full_ctl.first      = r_at_start;
    assign w_full_ctl.prev_lower = r_prev_lower;

    assign w_seg_ctl.step        = w_in_adv && !w_slash;
    assign w_seg_ctl.clear       = w_in_adv && (r_in_last || w_slash);
    assign w_seg_ctl.first       = !r_seg_nonempty;
    assign w_seg_ctl.prev_lower  = r_seg_prev_lower;

    fss_lane #(.QUERY_MAX(QUERY_MAX), .QP_W(QP_W)) u_full_lane (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_full_ctl),
        .i_char  (r_in_char),
        .i_qlen  (w_qlen),
        .i_query (w_query),
        .o_stat  (w_full_stat)
    );

    fss_lane #(.QUERY_MAX(QUERY_MAX), .QP_W(QP_W)) u_seg_lane (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_seg_ctl),
        .i_char  (r_in_char),
        .i_qlen  (w_qlen),
        .i_query (w_query),
        .o_stat  (w_seg_stat)
    );

    // Snapshot of the candidate's final lane state
    logic               r_snap_matched;
    logic [TOTAL_W-1:0] r_snap_full;
    logic               r_snap_seg_ok;
    logic [TOTAL_W-1:0] r_snap_seg;
    logic               r_snap_path;
    logic [SLASH_W-1:0] r_snap_slash;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_valid <= 1'b0;
        end else if (w_in_adv && r_in_last) begin
            r_snap_valid <= 1'b1;
        end else if (w_snap_adv) begin
            r_snap_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_adv && r_in_last) begin
            r_snap_matched <= w_full_stat.done;
            r_snap_full    <= w_full_stat.total;
            r_snap_seg_ok  <= r_path_mode && (n_slash != '0) && n_seg_nonempty &&
                              w_seg_stat.done;
            r_snap_seg     <= w_seg_stat.total;
            r_snap_path    <= r_path_mode;
            r_snap_slash   <= n_slash;
        end
    end

    // Final score: filename preference, then slash depth penalty
    logic [SCORE_W-1:0] w_base, w_alt, w_best, w_score;

    assign w_base  = {1'b0, r_snap_full};
    assign w_alt   = {1'b0, r_snap_seg} + SCORE_W'(SEG_BONUS);
    assign w_best  = (r_snap_seg_ok && (w_alt > w_base)) ? w_alt : w_base;
    assign w_score = r_snap_path ? (w_best - {1'b0, r_snap_slash, 1'b0}) : w_best;

    // Result register
    logic               r_out_matched;
    logic [SCORE_W-1:0] r_out_score;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_snap_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_snap_adv) begin
            r_out_matched <= r_snap_matched;
            r_out_score   <= r_snap_matched ? w_score : '0;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.matched     = r_out_matched;
    assign o_res.match_score = $signed(r_out_score);

`ifndef SYNTH
    // An unmatched candidate always reports a zero score
    a_unmatched_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_matched) |-> (r_out_score == '0))
        else $error("unmatched result with nonzero score");

    // A final character held back keeps its register contents
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_in_adv) |=> (r_in_valid && $stable(r_in_char) && $stable(r_in_last)))
        else $error("held input character lost");

    // A stalled snapshot is not dropped
    a_snap_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_snap_valid && !w_out_ready) |=> (r_snap_valid && $stable(r_snap_full)))
        else $error("stalled snapshot lost");

    // After a final character the per-candidate state starts over
    a_cand_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_adv && r_in_last) |=> (r_at_start && (r_slash == '0) && !r_seg_nonempty))
        else $error("candidate state not cleared");
`endif

endmodule

`default_nettype wire

>>> sim/fss_checker.sv
`timescale 1ns / 100ps
// fss_checker: watches the candidate and result request channels and the
// configuration port, predicts each score and compares it. Depends on fss_pkg.

module fss_checker
    import fss_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CIDX_W-1:0]         i_cfg_index,
    input  logic [CFG_W-1:0]          i_cfg_data,
    input  logic                      i_cand_valid,
    input  logic                      i_cand_ready,
    input  logic [CHAR_W-1:0]         i_cand_char,
    input  logic                      i_cand_last,
    input  logic                      i_res_valid,
    input  logic                      i_res_ready,
    input  logic                      i_res_matched,
    input  logic signed [SCORE_W-1:0] i_res_score,
    output int                        o_pending,
    output int                        o_fail_count
);

    localparam int QUERY_SLOTS = 32;
    localparam int REPORT_MAX  = 40;

    typedef struct packed {
        logic [QLEN_W-1:0]  qpos;
        logic [TOTAL_W-1:0] total;
        logic               prev_hit;
        logic               at_bound;
        logic [GAP_W-1:0]   gap;
        logic               any_hit;
    } t_lane_state;

    typedef struct packed {
        logic                      matched;
        logic signed [SCORE_W-1:0] score;
    } t_score;

    // Configuration copy
    logic              path_on;
    logic [QLEN_W-1:0] qlen_reg;
    logic [CFG_W-1:0]  qwords [4];

    // Per-candidate state
    t_lane_state       full_ln;
    t_lane_state       seg_ln;
    logic              seg_started;
    logic              seg_last_lower;
    logic              last_lower;
    logic              fresh;
    logic [SLASH_W-1:0] slashes;

    t_score expected_scores [$];
    int     fails;

    function automatic logic ch_upper(input logic [CHAR_W-1:0] c);
        return (c >= 8'h41) && (c <= 8'h5A);
    endfunction

    function automatic logic ch_lower(input logic [CHAR_W-1:0] c);
        return (c >= 8'h61) && (c <= 8'h7A);
    endfunction

    function automatic logic [CHAR_W-1:0] ch_fold(input logic [CHAR_W-1:0] c);
        return ch_upper(c) ? c + 8'd32 : c;
    endfunction

    function automatic logic ch_sep(input logic [CHAR_W-1:0] c);
        return (c == CH_SLASH) || (c == CH_BSLASH) || (c == CH_UNDER) || (c == CH_DASH) ||
               (c == CH_DOT) || (c == CH_SPACE) || (c == CH_DOLLAR);
    endfunction

    // Lengths above the query store count as a full store
    function automatic logic [QLEN_W-1:0] used_len();
        return (qlen_reg > QUERY_SLOTS) ? QLEN_W'(QUERY_SLOTS) : qlen_reg;
    endfunction

    function automatic logic [CHAR_W-1:0] query_byte(input logic [QLEN_W-1:0] pos);
        return qwords[pos[4:3]][pos[2:0]*8 +: 8];
    endfunction

    function automatic t_lane_state lane_idle();
        t_lane_state ln;
        ln          = '0;
        ln.at_bound = 1'b1;
        return ln;
    endfunction

    // One character through one lane: greedy case-folded match and its points
    function automatic t_lane_state advance_lane(input t_lane_state ln,
                                                 input logic [CHAR_W-1:0] c,
                                                 input logic first,
                                                 input logic prev_lower);
        t_lane_state        nx;
        logic [TOTAL_W-1:0] gain;
        logic               up;
        logic               bnext;
        nx    = ln;
        up    = ch_upper(c);
        bnext = ch_sep(c) || (!first && prev_lower && up);
        if (ln.qpos >= used_len())
            return ln;
        if (ch_fold(c) == ch_fold(query_byte(ln.qpos))) begin
            gain = TOTAL_W'(SCORE_BASE);
            if (ln.prev_hit)
                gain = gain + TOTAL_W'(BONUS_CONSEC);
            if (ln.at_bound || first)
                gain = gain + TOTAL_W'(BONUS_BOUNDARY);
            if (up)
                gain = gain + TOTAL_W'(BONUS_UPPER);
            if (ln.any_hit && ln.gap != 0)
                gain = gain - TOTAL_W'(ln.gap);
            nx.total    = ln.total + gain;
            nx.qpos     = ln.qpos + 1'b1;
            nx.prev_hit = 1'b1;
            nx.gap      = '0;
            nx.any_hit  = 1'b1;
        end else begin
            nx.prev_hit = 1'b0;
            if (ln.gap < GAP_SAT)
                nx.gap = ln.gap + 1'b1;
        end
        nx.at_bound = bnext;
        return nx;
    endfunction

    function automatic t_score final_score();
        t_score r;
        int     sc;
        int     alt;
        r = '0;
        if (full_ln.qpos >= used_len()) begin
            sc = int'(full_ln.total);
            if (path_on) begin
                // Filename preference, then the depth penalty
                if (slashes != 0 && seg_started && seg_ln.qpos >= used_len()) begin
                    alt = int'(seg_ln.total) + SEG_BONUS;
                    if (alt > sc)
                        sc = alt;
                end
                sc = sc - 2 * int'(slashes);
            end
            r.matched = 1'b1;
            r.score   = sc[SCORE_W-1:0];
        end
        return r;
    endfunction

    task automatic clear_stream();
        full_ln        = lane_idle();
        seg_ln         = lane_idle();
        seg_started    = 1'b0;
        seg_last_lower = 1'b0;
        last_lower     = 1'b0;
        fresh          = 1'b1;
        slashes        = '0;
    endtask

    always @(posedge i_clk) begin : score_track
        t_score            want;
        logic [CHAR_W-1:0] c;
        if (!i_rst_n) begin
            path_on  = 1'b0;
            qlen_reg = '0;
            for (int k = 0; k < 4; k++)
                qwords[k] = '0;
            clear_stream();
            expected_scores.delete();
            fails = 0;
        end else begin
            // Result side
            if (i_res_valid && i_res_ready) begin
                if (expected_scores.size() == 0) begin
                    fails++;
                    if (fails <= REPORT_MAX)
                        $display("%0t: unexpected result matched=%0b score=%0d",
                                 $time, i_res_matched, i_res_score);
                end else begin
                    want = expected_scores.pop_front();
                    if (i_res_matched !== want.matched) begin
                        fails++;
                        if (fails <= REPORT_MAX)
                            $display("%0t: matched expected %0b actual %0b",
                                     $time, want.matched, i_res_matched);
                    end
                    if (i_res_score !== want.score) begin
                        fails++;
                        if (fails <= REPORT_MAX)
                            $display("%0t: match_score expected %0d actual %0d",
                                     $time, want.score, i_res_score);
                    end
                end
            end

            // Register writes; unknown indexes change nothing
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_PATH_MODE: path_on   = i_cfg_data[0];
                    REG_QUERY_LEN: qlen_reg  = i_cfg_data[QLEN_W-1:0];
                    REG_QUERY_0:   qwords[0] = i_cfg_data;
                    REG_QUERY_1:   qwords[1] = i_cfg_data;
                    REG_QUERY_2:   qwords[2] = i_cfg_data;
                    REG_QUERY_3:   qwords[3] = i_cfg_data;
                    default: ;
                endcase
            end

            // Candidate side
            if (i_cand_valid && i_cand_ready) begin
                c       = i_cand_char;
                full_ln = advance_lane(full_ln, c, fresh, last_lower);
                if (c == CH_SLASH) begin
                    seg_ln         = lane_idle();
                    seg_started    = 1'b0;
                    seg_last_lower = 1'b0;
                    if (slashes < SLASH_SAT)
                        slashes = slashes + 1'b1;
                end else begin
                    seg_ln         = advance_lane(seg_ln, c, !seg_started, seg_last_lower);
                    seg_started    = 1'b1;
                    seg_last_lower = ch_lower(c);
                end
                last_lower = ch_lower(c);
                fresh      = 1'b0;
                if (i_cand_last) begin
                    expected_scores.push_back(final_score());
                    clear_stream();
                end
            end
        end
        o_pending    <= expected_scores.size();
        o_fail_count <= fails;
    end

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps
// tb: drives candidate strings and query settings into the fuzzy subsequence
// scorer and gives the verdict. Depends on fss_pkg, fss_if and fss_checker.

module tb;
    import fss_pkg::*;

    localparam int PAUSE        = 6;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_CHARS = 384;
    localparam int SEGMENTS     = 12;
    localparam int QUERY_SLOTS  = 32;

    // Indexes past the last register
    localparam logic [CIDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CIDX_W-1:0] REG_SPARE_7 = 3'd7;

    logic               i_clk      = 1'b0;
    logic               i_rst_n    = 1'b0;
    logic               cfg_we     = 1'b0;
    logic [CIDX_W-1:0]  cfg_index  = '0;
    logic [CFG_W-1:0]   cfg_data   = '0;
    logic               cand_valid = 1'b0;
    logic [CHAR_W-1:0]  cand_char  = '0;
    logic               cand_last  = 1'b0;
    logic               res_ready  = 1'b0;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int pending;
    int fail_count;

    logic [CHAR_W-1:0] qchars [QUERY_SLOTS];
    logic [CHAR_W-1:0] cand_q [$];

    fss_in_if  cand_if ();
    fss_out_if res_if ();

    assign cand_if.valid     = cand_valid;
    assign cand_if.char_code = cand_char;
    assign cand_if.last_char = cand_last;
    assign res_if.ready      = res_ready;

    fuzzy_subsequence_scorer u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_cand      (cand_if),
        .o_res       (res_if)
    );

    fss_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_cand_valid  (cand_if.valid),
        .i_cand_ready  (cand_if.ready),
        .i_cand_char   (cand_if.char_code),
        .i_cand_last   (cand_if.last_char),
        .i_res_valid   (res_if.valid),
        .i_res_ready   (res_if.ready),
        .i_res_matched (res_if.matched),
        .i_res_score   (res_if.match_score),
        .o_pending     (pending),
        .o_fail_count  (fail_count)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Result receiver stalls at random
    always @(posedge i_clk) begin
        res_ready <= ($urandom_range(99, 0) >= rx_idle_pct);
    end

    // Run limit
    initial begin
        int cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Mismatches found");
        $finish;
    end

    function automatic logic [CHAR_W-1:0] pick_letter();
        logic [CHAR_W-1:0] c;
        c = 8'h61 + 8'($urandom_range(25, 0));
        return $urandom_range(1, 0) ? c - 8'd32 : c;
    endfunction

    function automatic logic [CHAR_W-1:0] pick_sep();
        case ($urandom_range(6, 0))
            0:       return CH_SLASH;
            1:       return CH_BSLASH;
            2:       return CH_UNDER;
            3:       return CH_DASH;
            4:       return CH_DOT;
            5:       return CH_SPACE;
            default: return CH_DOLLAR;
        endcase
    endfunction

    function automatic logic [CHAR_W-1:0] pick_noise();
        int r;
        r = $urandom_range(9, 0);
        if (r < 3)
            return 8'($urandom_range(255, 0));
        if (r < 8)
            return pick_letter();
        return pick_sep();
    endfunction

    function automatic logic [CHAR_W-1:0] pick_query_char();
        int r;
        r = $urandom_range(19, 0);
        if (r < 14)
            return pick_letter();
        if (r < 16)
            return 8'h30 + 8'($urandom_range(9, 0));
        if (r < 19)
            return pick_sep();
        return 8'($urandom_range(255, 0));
    endfunction

    // Letters come back in either case; other bytes unchanged
    function automatic logic [CHAR_W-1:0] vary_case(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] low;
        low = c | 8'h20;
        if (low >= 8'h61 && low <= 8'h7A && $urandom_range(1, 0))
            return c ^ 8'h20;
        return c;
    endfunction

    task automatic put_char(input logic [CHAR_W-1:0] c, input logic last);
        while ($urandom_range(99, 0) < tx_idle_pct) begin
            cand_valid <= 1'b0;
            @(posedge i_clk);
        end
        cand_valid <= 1'b1;
        cand_char  <= c;
        cand_last  <= last;
        do @(posedge i_clk); while (!cand_if.ready);
    endtask

    task automatic send_candidate();
        foreach (cand_q[i])
            put_char(cand_q[i], i == cand_q.size() - 1);
        cand_q.delete();
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            cand_q.push_back(s[i]);
        send_candidate();
    endtask

    // Drain every outstanding score, then let the pipeline settle
    task automatic wait_idle();
        cand_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (PAUSE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
    endtask

    task automatic set_query_text(input string s);
        for (int k = 0; k < QUERY_SLOTS; k++)
            qchars[k] = (k < s.len()) ? s[k] : 8'($urandom);
    endtask

    // Write every register; unused upper data bits are random
    task automatic load_config(input logic pm, input logic [QLEN_W-1:0] qlen);
        logic [CFG_W-1:0] words [4];
        logic [CFG_W-1:0] junk;
        for (int k = 0; k < QUERY_SLOTS; k++)
            words[k / 8][(k % 8) * 8 +: 8] = qchars[k];
        if ($urandom_range(3, 0) == 0)
            write_reg($urandom_range(1, 0) ? REG_SPARE_6 : REG_SPARE_7, {$urandom, $urandom});
        junk = {$urandom, $urandom};
        write_reg(REG_PATH_MODE, {junk[CFG_W-1:1], pm});
        junk = {$urandom, $urandom};
        write_reg(REG_QUERY_LEN, {junk[CFG_W-1:QLEN_W], qlen});
        write_reg(REG_QUERY_0, words[0]);
        write_reg(REG_QUERY_1, words[1]);
        write_reg(REG_QUERY_2, words[2]);
        write_reg(REG_QUERY_3, words[3]);
        cfg_we <= 1'b0;
    endtask

    // Mostly the query spread out with noise, case changes and path parts
    task automatic build_candidate(input logic pm, input int used);
        int kind;
        int reps;
        int gap;
        kind = $urandom_range(9, 0);
        if (kind >= 8) begin
            repeat ($urandom_range(12, 1)) cand_q.push_back(pick_noise());
        end else begin
            reps = (kind >= 6) ? 2 : 1;
            if (pm && $urandom_range(1, 0)) begin
                repeat ($urandom_range(3, 1)) begin
                    repeat ($urandom_range(4, 0)) cand_q.push_back(pick_letter());
                    cand_q.push_back(CH_SLASH);
                end
            end
            for (int r = 0; r < reps; r++) begin
                if (r > 0)
                    cand_q.push_back(CH_SLASH);
                for (int i = 0; i < used; i++) begin
                    if ($urandom_range(19, 0) == 0)
                        continue;
                    gap = ($urandom_range(3, 0) == 0) ? $urandom_range(9, 0)
                                                      : $urandom_range(1, 0);
                    repeat (gap) cand_q.push_back(pick_noise());
                    if (pm && $urandom_range(9, 0) == 0)
                        cand_q.push_back(CH_SLASH);
                    cand_q.push_back(vary_case(qchars[i]));
                end
            end
            repeat ($urandom_range(2, 0)) cand_q.push_back(pick_noise());
            if (pm && $urandom_range(7, 0) == 0)
                cand_q.push_back(CH_SLASH);
        end
        if (cand_q.size() == 0)
            cand_q.push_back(pick_noise());
    endtask

    initial begin
        int               sent;
        int               used;
        logic             pm;
        logic [QLEN_W-1:0] qlen;
        string            long_q;

        tx_idle_pct = 19;
        rx_idle_pct = 76;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: empty query
        send_text("q");

        // Empty query with the filename rule
        wait_idle();
        set_query_text("");
        load_config(1'b1, 6'd0);
        send_text("ab/c");

        // Bonuses, camel step, separators, gaps and bytes without case
        wait_idle();
        set_query_text("Ab");
        load_config(1'b0, 6'd2);
        send_text("ab");
        send_text("xAyB");
        send_text("a_b");
        send_text("xaB");
        send_text("ba");
        send_text("a.........b");
        send_text("a\\B$");
        cand_q = '{8'h00, 8'h61, 8'hFF, 8'h62, 8'h80};
        send_candidate();

        // Final segment preference and slash penalty
        wait_idle();
        set_query_text("ab");
        load_config(1'b1, 6'd2);
        send_text("src/ab");
        send_text("ab/x/ab");
        send_text("a/b");
        send_text("ab/");
        send_text("/AB");

        // Full query store, length register above the store size
        wait_idle();
        long_q = "AbCdEfGhIjKlMnOpQrStUvWxYz_0-1.2";
        set_query_text(long_q);
        load_config(1'b0, 6'd63);
        send_text(long_q);
        wait_idle();
        load_config(1'b1, 6'd32);
        send_text({"x/", long_q});

        // Slash count saturation; spare indexes must change nothing
        wait_idle();
        set_query_text("a");
        write_reg(REG_SPARE_6, '1);
        write_reg(REG_SPARE_7, {$urandom, $urandom});
        load_config(1'b1, 6'd1);
        repeat (1030) cand_q.push_back(CH_SLASH);
        cand_q.push_back(8'h61);
        send_candidate();

        // Random part: new query and settings per segment
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            wait_idle();
            if (seg < SEGMENTS / 3) begin
                tx_idle_pct = 19;
                rx_idle_pct = 76;
            end else if (seg < 2 * SEGMENTS / 3) begin
                tx_idle_pct = 76;
                rx_idle_pct = 19;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            pm = seg[0];
            case ((seg / 2) % 6)
                0:       qlen = 6'd0;
                1:       qlen = 6'd32;
                2:       qlen = 6'd63;
                3:       qlen = QLEN_W'($urandom_range(3, 1));
                default: qlen = QLEN_W'($urandom_range(12, 1));
            endcase
            used = (qlen > QUERY_SLOTS) ? QUERY_SLOTS : qlen;
            for (int k = 0; k < QUERY_SLOTS; k++)
                qchars[k] = pick_query_char();
            load_config(pm, qlen);
            sent = 0;
            while (sent < RANDOM_CHARS / SEGMENTS) begin
                build_candidate(pm, used);
                sent += cand_q.size();
                send_candidate();
            end
        end

        wait_idle();
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
